>>> design/wos_pkg.sv
package wos_pkg;

	// field widths
	localparam int IDX_W    = 32;
	localparam int FREQ_W   = 18;
	localparam int SR_W     = 18;
	localparam int AMP_W    = 15;
	localparam int BASE_W   = 15;
	localparam int DET_W    = 6;
	localparam int DUTY_W   = 7;
	localparam int WAVE_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 18;
	localparam int CFG_IDX_W = 3;

	// limits
	localparam int AMP_MAX          = 32767;
	localparam int DETUNE_RANGE     = 24;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int DUTY_FULL        = 100;

	// reset values of the registers
	localparam int RST_AMPLITUDE   = 32767;
	localparam int RST_BASE_FREQ   = 440;
	localparam int RST_DUTY        = 50;
	localparam int RST_SAMPLE_RATE = 44100;

	// semitone ratio, unsigned q24
	localparam int RATIO_W    = 25;
	localparam int RATIO_FRAC = 24;
	localparam int OCT_BIAS   = 4;

	// phase remainder pipeline
	localparam int PROD_W     = IDX_W + FREQ_W;
	localparam int MOD_STEPS  = 4;
	localparam int MOD_STAGES = (PROD_W + MOD_STEPS - 1) / MOD_STEPS;

	// shared divider
	localparam int DEN_W      = 25;
	localparam int DIV_STAGES = 3;
	localparam int TRI_Q_W    = 15;

	// quarter sine entries, unsigned q30
	localparam int          ENTRY_W     = 31;
	localparam int          ENTRY_FRAC  = 30;
	localparam longint      Q30_ONE     = 64'd1 << 30;
	localparam longint      HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [WAVE_W-1:0] {
		WAVE_SINE,
		WAVE_SQUARE,
		WAVE_TRIANGLE,
		WAVE_UNKNOWN
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVEFORM,
		REG_ENABLE,
		REG_AMPLITUDE,
		REG_BASE_FREQ,
		REG_DETUNE,
		REG_DUTY,
		REG_SAMPLE_RATE
	} cfg_reg_t;

	function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [3:0] semi);
		logic [RATIO_W-1:0] r;
		unique case (semi)
			4'd0:    r = 25'd16777216;
			4'd1:    r = 25'd17774841;
			4'd2:    r = 25'd18831788;
			4'd3:    r = 25'd19951585;
			4'd4:    r = 25'd21137968;
			4'd5:    r = 25'd22394897;
			4'd6:    r = 25'd23726566;
			4'd7:    r = 25'd25137421;
			4'd8:    r = 25'd26632170;
			4'd9:    r = 25'd28215802;
			4'd10:   r = 25'd29893600;
			4'd11:   r = 25'd31671166;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

	// taylor series of sin, evaluated at elaboration for each table entry
	function automatic logic [ENTRY_W-1:0] quarter_sine(input int unsigned idx,
			input int unsigned Depth);
		longint unsigned th;
		longint unsigned th2;
		longint unsigned term;
		longint unsigned Den;
		longint          sum;
		th   = (HALF_PI_Q30 * longint'(idx)) / Depth;
		th2  = (th * th) >> ENTRY_FRAC;
		term = th;
		sum  = longint'(th);
		for (int n = 1; n <= 10; n++) begin
			Den  = longint'((2 * n) * (2 * n + 1));
			term = ((term * th2) >> ENTRY_FRAC) / Den;
			if ((n & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > Q30_ONE)
			sum = Q30_ONE;
		return ENTRY_W'(sum);
	endfunction

endpackage

>>> design/wos_rstep.sv
module wos_rstep #(
	parameter int W     = 18,
	parameter int STEPS = 4
) (
	input  logic [W-1:0]     rem_in,
	input  logic [STEPS-1:0] bits,
	input  logic [W-1:0]     den,
	output logic [W-1:0]     rem_out,
	output logic [STEPS-1:0] quo
);

	// restoring steps, one numerator bit each, msb first
	always_comb begin
		logic [W:0]   t;
		logic [W-1:0] r;
		r   = rem_in;
		quo = '0;
		for (int i = STEPS - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, den}) begin
				t      = t - {1'b0, den};
				quo[i] = 1'b1;
			end
			r = t[W-1:0];
		end
		rem_out = r;
	end

endmodule

>>> design/wos_divp.sv
module wos_divp #(
	parameter int W      = 18,
	parameter int STEPS  = 4,
	parameter int STAGES = 13
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [STEPS*STAGES+W-1:0] num,
	input  logic [W-1:0]              den,
	output logic [STEPS*STAGES-1:0]   quo,
	output logic [W-1:0]              rem
);

	localparam int QP = STEPS * STAGES;

	// one entry per stage; low part holds the unused numerator bits on top
	// and the quotient bits gathered so far below
	logic [W-1:0]  rem_sn [STAGES];
	logic [QP-1:0] low_sn [STAGES];
	logic [W-1:0]  den_sn [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [W-1:0]     r_in;
		logic [W-1:0]     d_in;
		logic [W-1:0]     r_out;
		logic [QP-1:0]    l_in;
		logic [STEPS-1:0] q;

		if (g == 0) begin : g_first
			assign r_in = num[QP+W-1:QP];
			assign l_in = num[QP-1:0];
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_sn[g-1];
			assign l_in = low_sn[g-1];
			assign d_in = den_sn[g-1];
		end

		wos_rstep #(
			.W     (W),
			.STEPS (STEPS)
		) u_step (
			.rem_in  (r_in),
			.bits    (l_in[QP-1 -: STEPS]),
			.den     (d_in),
			.rem_out (r_out),
			.quo     (q)
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[g] <= r_out;
				low_sn[g] <= {l_in[QP-STEPS-1:0], q};
				den_sn[g] <= d_in;
			end
		end
	end

	assign quo = low_sn[STAGES-1];
	assign rem = rem_sn[STAGES-1];

endmodule

>>> design/wos_freq.sv
module wos_freq (
	input  logic                        clk,
	input  logic [wos_pkg::BASE_W-1:0]  base_freq,
	input  logic [wos_pkg::DET_W-1:0]   detune,
	output logic [wos_pkg::FREQ_W-1:0]  freq
);
	import wos_pkg::*;

	localparam int X_W  = BASE_W + RATIO_W;
	localparam int XS_W = X_W + 6;

	logic signed [7:0]  d_ext;
	logic signed [7:0]  d_clamp;
	logic [6:0]         t;
	logic [12:0]        t43;
	logic [2:0]         oct_idx;
	logic [6:0]         semi7;
	logic [X_W-1:0]     x;
	logic [X_W-1:0]     x_q;
	logic [2:0]         oct_q;
	logic [XS_W-1:0]    xs;
	logic [FREQ_W-1:0]  fr;
	logic [FREQ_W-1:0]  freq_q;

	always_comb begin
		d_ext = {{2{detune[DET_W-1]}}, detune};
		priority if (d_ext > signed'(8'(DETUNE_RANGE)))
			d_clamp = signed'(8'(DETUNE_RANGE));
		else if (d_ext < -signed'(8'(DETUNE_RANGE)))
			d_clamp = -signed'(8'(DETUNE_RANGE));
		else
			d_clamp = d_ext;
		// bias by four octaves so the octave number is never negative
		t       = 7'(d_clamp + 8'sd48);
		// octave of t by twelve as (t * 43) >> 9, exact for t below 128
		t43     = 13'(t) * 13'd43;
		oct_idx = 3'(t43 >> 9);
		semi7   = t - 7'(oct_idx) * 7'd12;
		x       = X_W'(base_freq) * X_W'(semitone_ratio(semi7[3:0]));
	end

	always_ff @(posedge clk) begin
		x_q   <= x;
		oct_q <= oct_idx;
	end

	always_comb begin
		xs = XS_W'(x_q) << oct_q;
		fr = xs[RATIO_FRAC+OCT_BIAS +: FREQ_W];
	end

	always_ff @(posedge clk) begin
		freq_q <= (fr == '0) ? FREQ_W'(1) : fr;
	end

	assign freq = freq_q;

endmodule

>>> design/wos_shape.sv
module wos_shape #(
	parameter int DEPTH = wos_pkg::SINE_TABLE_DEPTH,
	parameter int QP    = 15
) (
	input  logic                                clk,
	input  logic                                adv,
	input  logic [QP-1:0]                       quo,
	input  logic                                rise,
	input  wos_pkg::wave_t                      wave,
	input  logic                                enable,
	input  logic [wos_pkg::AMP_W-1:0]           amp,
	output logic signed [wos_pkg::SAMPLE_W-1:0] value,
	output logic                                err
);
	import wos_pkg::*;

	localparam int POS_W  = $clog2(4 * DEPTH);
	localparam int ADDR_W = $clog2(DEPTH + 1);
	localparam int MUL_W  = AMP_W + ENTRY_W;

	logic [ENTRY_W-1:0] qsine_rom [DEPTH+1];

	for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
		assign qsine_rom[g] = quarter_sine(g, DEPTH);
	end

	logic [POS_W-1:0]   pos;
	logic [1:0]         quad;
	logic [POS_W-1:0]   off;
	logic [ADDR_W-1:0]  addr;

	logic [ENTRY_W-1:0] ent_s1;
	logic               neg_s1;
	logic               rise_s1;
	logic [TRI_Q_W-1:0] tq_s1;

	logic [AMP_W-1:0]   mag_s2;
	logic               neg_s2;
	logic               rise_s2;
	logic [TRI_Q_W-1:0] tq_s2;

	logic [MUL_W-1:0]   sm;

	always_comb begin
		pos = quo[POS_W-1:0];
		priority if (pos >= POS_W'(3 * DEPTH)) begin
			quad = 2'd3;
			off  = pos - POS_W'(3 * DEPTH);
		end else if (pos >= POS_W'(2 * DEPTH)) begin
			quad = 2'd2;
			off  = pos - POS_W'(2 * DEPTH);
		end else if (pos >= POS_W'(DEPTH)) begin
			quad = 2'd1;
			off  = pos - POS_W'(DEPTH);
		end else begin
			quad = 2'd0;
			off  = pos;
		end
		// odd quadrants run the table backwards
		addr = quad[0] ? ADDR_W'(DEPTH) - ADDR_W'(off) : ADDR_W'(off);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1  <= qsine_rom[addr];
			neg_s1  <= quad[1];
			rise_s1 <= rise;
			tq_s1   <= quo[TRI_Q_W-1:0];
		end
	end

	assign sm = MUL_W'(amp) * MUL_W'(ent_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2  <= sm[ENTRY_FRAC +: AMP_W];
			neg_s2  <= neg_s1;
			rise_s2 <= rise_s1;
			tq_s2   <= tq_s1;
		end
	end

	always_comb begin
		logic signed [17:0] amp_v;
		logic signed [17:0] half_v;
		logic signed [17:0] tq_v;
		logic signed [17:0] mag_v;
		logic signed [17:0] v;
		amp_v  = signed'(18'(amp));
		half_v = signed'(18'(amp >> 1));
		tq_v   = signed'(18'(tq_s2));
		mag_v  = signed'(18'(mag_s2));
		v      = '0;
		err    = 1'b0;
		if (enable) begin
			unique case (wave)
				WAVE_SINE:     v = neg_s2 ? -mag_v : mag_v;
				WAVE_SQUARE:   v = rise_s2 ? amp_v : -amp_v;
				WAVE_TRIANGLE: v = rise_s2 ? tq_v - half_v : half_v - tq_v;
				WAVE_UNKNOWN:  err = 1'b1;
			endcase
		end
		value = signed'(SAMPLE_W'(v));
	end

endmodule

>>> design/waveform_oscillator_sample.sv
// Direct digital synthesis oscillator: each sample_index beat gives one signed
// 16-bit sample_value (sine from a quarter-wave table, square or asymmetric
// triangle split by duty), in order, one index taken per clock while
// index_stall is low. The depth of the pipeline comes from the 50-bit
// index-times-frequency remainder, reduced four bits a stage over 13 stages,
// and the three-stage shared divider that scales the phase for the sine table
// and the triangle ramp. An output register with one skid entry behind it
// keeps the input open while a result waits; index_stall rises only when both
// are full. Registers are written through cfg_wr_en/cfg_index/cfg_data
// (0 waveform, 1 enable, 2 amplitude, 3 base_freq, 4 detune, 5 duty,
// 6 output rate) and must only change while no sample is in flight.
module waveform_oscillator_sample #(
	parameter int SINE_TABLE_DEPTH = wos_pkg::SINE_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wos_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wos_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                index_valid,
	output logic                                index_stall,
	input  logic [wos_pkg::IDX_W-1:0]           sample_index,
	output logic                                sample_valid,
	input  logic                                sample_stall,
	output logic signed [wos_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                error
);
	import wos_pkg::*;

	localparam int POS_W     = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int QB        = (POS_W > TRI_Q_W) ? POS_W : TRI_Q_W;
	localparam int DIV_STEPS = (QB + DIV_STAGES - 1) / DIV_STAGES;
	localparam int QP        = DIV_STEPS * DIV_STAGES;
	localparam int NUM_W     = QP + DEN_W;
	localparam int MOD_NW    = MOD_STEPS * MOD_STAGES;
	localparam int NPIPE     = 4 + MOD_STAGES + 2 + DIV_STAGES + 2;

	// configuration
	wave_t              waveform_q;
	logic               enable_q;
	logic [AMP_W-1:0]   amplitude_q;
	logic [BASE_W-1:0]  base_freq_q;
	logic [DET_W-1:0]   detune_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [SR_W-1:0]    out_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q    <= WAVE_SINE;
			enable_q      <= 1'b0;
			amplitude_q   <= AMP_W'(RST_AMPLITUDE);
			base_freq_q   <= BASE_W'(RST_BASE_FREQ);
			detune_q      <= '0;
			duty_q        <= DUTY_W'(RST_DUTY);
			out_rate_q    <= SR_W'(RST_SAMPLE_RATE);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WAVEFORM:    waveform_q    <= wave_t'(cfg_data[WAVE_W-1:0]);
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_AMPLITUDE:   amplitude_q   <= cfg_data[AMP_W-1:0];
				REG_BASE_FREQ:   base_freq_q   <= cfg_data[BASE_W-1:0];
				REG_DETUNE:      detune_q      <= cfg_data[DET_W-1:0];
				REG_DUTY:        duty_q        <= cfg_data[DUTY_W-1:0];
				REG_SAMPLE_RATE: out_rate_q    <= cfg_data[SR_W-1:0];
				default: ;
			endcase
		end
	end

	// values derived from the registers, settled long before a beat needs them
	logic [SR_W-1:0]   sr_eff;
	logic [DUTY_W-1:0] dc_eff;
	logic [SR_W-1:0]   sr_eff_q;
	logic [AMP_W-1:0]  amp_eff_q;
	logic [DEN_W-1:0]  dcsr_q;
	logic [DEN_W-1:0]  fdsr_q;
	logic [FREQ_W-1:0] freq;

	always_comb begin
		sr_eff = (out_rate_q == '0) ? SR_W'(1) : out_rate_q;
		priority if (duty_q == '0)
			dc_eff = DUTY_W'(1);
		else if (duty_q > DUTY_W'(DUTY_FULL))
			dc_eff = DUTY_W'(DUTY_FULL);
		else
			dc_eff = duty_q;
	end

	always_ff @(posedge clk) begin
		sr_eff_q  <= sr_eff;
		amp_eff_q <= (amplitude_q > AMP_W'(AMP_MAX)) ? AMP_W'(AMP_MAX) : amplitude_q;
		dcsr_q    <= DEN_W'(dc_eff) * DEN_W'(sr_eff);
		fdsr_q    <= DEN_W'(DUTY_W'(DUTY_FULL) - dc_eff) * DEN_W'(sr_eff);
	end

	wos_freq u_freq (
		.clk       (clk),
		.base_freq (base_freq_q),
		.detune    (detune_q),
		.freq      (freq)
	);

	// handshake: the whole pipe moves unless the skid entry is occupied
	logic             adv;
	logic [NPIPE-1:0] vld_q;
	logic             skid_v_q;
	logic             out_v_q;
	logic             take;

	assign adv         = !skid_v_q;
	assign index_stall = skid_v_q;
	assign take        = out_v_q && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NPIPE-2:0], index_valid};
	end

	// index stages give the frequency registers time after a write
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  idx_s2;
	logic [IDX_W-1:0]  idx_s3;
	logic [PROD_W-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= sample_index;
			idx_s2  <= idx_s1;
			idx_s3  <= idx_s2;
			prod_s4 <= PROD_W'(idx_s3) * PROD_W'(freq);
		end
	end

	// phase = product mod sample rate
	logic [SR_W-1:0] phase;

	wos_divp #(
		.W      (SR_W),
		.STEPS  (MOD_STEPS),
		.STAGES (MOD_STAGES)
	) u_mod (
		.clk (clk),
		.adv (adv),
		.num ({SR_W'(0), MOD_NW'(prod_s4)}),
		.den (sr_eff_q),
		.quo (),
		.rem (phase)
	);

	// rising or high part test, and the numerator for the ramp
	logic [SR_W-1:0]  p_s18;
	logic             rise_s18;
	logic [DEN_W-1:0] diff_s18;
	logic [DEN_W-1:0] hp;

	assign hp = DEN_W'(phase) * DEN_W'(DUTY_FULL);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s18    <= phase;
			rise_s18 <= hp < dcsr_q;
			diff_s18 <= (hp < dcsr_q) ? hp : hp - dcsr_q;
		end
	end

	logic [NUM_W-1:0] num_s19;
	logic [DEN_W-1:0] den_s19;
	logic             rise_s19;

	always_ff @(posedge clk) begin
		if (adv) begin
			rise_s19 <= rise_s18;
			if (waveform_q == WAVE_SINE) begin
				num_s19 <= NUM_W'(p_s18) * NUM_W'(4 * SINE_TABLE_DEPTH);
				den_s19 <= DEN_W'(sr_eff_q);
			end else begin
				num_s19 <= NUM_W'(diff_s18) * NUM_W'(amp_eff_q);
				den_s19 <= rise_s18 ? dcsr_q : fdsr_q;
			end
		end
	end

	logic [QP-1:0]    quo;
	logic             rise_s20;
	logic             rise_s21;
	logic             rise_s22;

	wos_divp #(
		.W      (DEN_W),
		.STEPS  (DIV_STEPS),
		.STAGES (DIV_STAGES)
	) u_div (
		.clk (clk),
		.adv (adv),
		.num (num_s19),
		.den (den_s19),
		.quo (quo),
		.rem ()
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			rise_s20 <= rise_s19;
			rise_s21 <= rise_s20;
			rise_s22 <= rise_s21;
		end
	end

	logic signed [SAMPLE_W-1:0] last_val;
	logic                       last_err;

	wos_shape #(
		.DEPTH (SINE_TABLE_DEPTH),
		.QP    (QP)
	) u_shape (
		.clk    (clk),
		.adv    (adv),
		.quo    (quo),
		.rise   (rise_s22),
		.wave   (waveform_q),
		.enable (enable_q),
		.amp    (amp_eff_q),
		.value  (last_val),
		.err    (last_err)
	);

	// output register and skid entry
	logic signed [SAMPLE_W-1:0] out_val_q;
	logic                       out_err_q;
	logic signed [SAMPLE_W-1:0] skid_val_q;
	logic                       skid_err_q;
	logic                       last_v;

	assign last_v = vld_q[NPIPE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take)
				skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			out_v_q <= last_v;
		end else if (last_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_val_q <= skid_val_q;
				out_err_q <= skid_err_q;
			end
		end else if (!out_v_q || take) begin
			out_val_q <= last_val;
			out_err_q <= last_err;
		end else begin
			skid_val_q <= last_val;
			skid_err_q <= last_err;
		end
	end

	assign sample_valid = out_v_q;
	assign sample_value = out_val_q;
	assign error        = out_err_q;

endmodule

>>> design/wos_chk.sv
module wos_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                index_valid,
	input logic                                index_stall,
	input logic                                sample_valid,
	input logic                                sample_stall,
	input logic signed [wos_pkg::SAMPLE_W-1:0] sample_value,
	input logic                                error
);

	// a flagged beat always carries a zero sample
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && error |-> sample_value == '0)
		else $error("error beat with non-zero sample");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample_value) && $stable(error))
		else $error("stalled result changed");

	// input is held off only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		index_stall |-> sample_valid)
		else $error("index stalled with no result waiting");

	// one result taken frees the input again
	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		index_stall && !sample_stall |=> !index_stall)
		else $error("index stall persisted after a result was taken");

endmodule

bind waveform_oscillator_sample wos_chk u_wos_chk (.*);

>>> tb/waveform_oscillator_sample_checker.sv
`timescale 1ns / 1ps

module waveform_oscillator_sample_checker
	import wos_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       index_valid,
	input  logic                       index_stall,
	input  logic [IDX_W-1:0]           sample_index,
	input  logic                       sample_valid,
	input  logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       error,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       err;
	} osc_sample_t;

	localparam longint unsigned SEMI_Q24 [12] = '{
		16777216, 17774841, 18831788, 19951585, 21137968, 22394897,
		23726566, 25137421, 26632170, 28215802, 29893600, 31671166
	};
	localparam longint unsigned HALF_PI = 64'd1686629713;
	localparam longint          UNIT_Q30 = 64'd1 << 30;

	wave_t              wave;
	logic               en;
	logic [AMP_W-1:0]   amp_reg;
	logic [BASE_W-1:0]  base_reg;
	logic [DET_W-1:0]   det_reg;
	logic [DUTY_W-1:0]  duty_reg;
	logic [SR_W-1:0]    rate_reg;

	longint unsigned sine_q30 [SINE_TABLE_DEPTH+1];
	osc_sample_t     expected_samples [$];

	initial begin
		longint unsigned th, th2, term;
		longint          acc;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			th   = HALF_PI * i / SINE_TABLE_DEPTH;
			th2  = (th * th) >> 30;
			term = th;
			acc  = longint'(th);
			for (int n = 1; n <= 10; n++) begin
				term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
				acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > UNIT_Q30)
				acc = UNIT_Q30;
			sine_q30[i] = acc;
		end
	end

	function automatic osc_sample_t predict_sample(input logic [IDX_W-1:0] idx);
		longint unsigned rate, amp, dc, x, f, p, pos, q, r, e, half;
		longint          v;
		int              d, t, oct;
		osc_sample_t     s;
		s.value = '0;
		s.err   = 1'b0;
		v       = 0;
		if (!en)
			return s;
		rate = (rate_reg == 0) ? 1 : rate_reg;
		amp  = (amp_reg > AMP_MAX) ? AMP_MAX : amp_reg;
		dc   = (duty_reg < 1) ? 1 : ((duty_reg > DUTY_FULL) ? DUTY_FULL : duty_reg);
		d    = $signed(det_reg);
		if (d > DETUNE_RANGE)
			d = DETUNE_RANGE;
		if (d < -DETUNE_RANGE)
			d = -DETUNE_RANGE;
		t   = d + 48;
		oct = t / 12 - 4;
		x   = longint'(base_reg) * SEMI_Q24[t % 12];
		f   = (oct >= 0) ? (x << oct) >> 24 : x >> (24 - oct);
		if (f < 1)
			f = 1;
		p = (longint'(idx) * f) % rate;
		case (wave)
			WAVE_SINE: begin
				pos = p * 4 * SINE_TABLE_DEPTH / rate;
				q   = pos / SINE_TABLE_DEPTH;
				r   = pos % SINE_TABLE_DEPTH;
				e   = q[0] ? sine_q30[SINE_TABLE_DEPTH - r] : sine_q30[r];
				v   = longint'((amp * e) >> 30);
				if (q[1])
					v = -v;
			end
			WAVE_SQUARE: begin
				v = (100 * p < dc * rate) ? longint'(amp) : -longint'(amp);
			end
			WAVE_TRIANGLE: begin
				half = amp / 2;
				if (100 * p < dc * rate)
					v = longint'(100 * p * amp / (dc * rate)) - longint'(half);
				else
					v = longint'(half)
						- longint'((100 * p - dc * rate) * amp / ((100 - dc) * rate));
			end
			default: begin
				s.err = 1'b1;
			end
		endcase
		s.value = v[SAMPLE_W-1:0];
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		osc_sample_t want;
		if (!arst_n) begin
			wave       <= WAVE_SINE;
			en         <= 1'b0;
			amp_reg    <= AMP_W'(RST_AMPLITUDE);
			base_reg   <= BASE_W'(RST_BASE_FREQ);
			det_reg    <= '0;
			duty_reg   <= DUTY_W'(RST_DUTY);
			rate_reg   <= SR_W'(RST_SAMPLE_RATE);
			fail_count = 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_WAVEFORM:    wave     <= wave_t'(cfg_data[WAVE_W-1:0]);
					REG_ENABLE:      en       <= cfg_data[0];
					REG_AMPLITUDE:   amp_reg  <= cfg_data[AMP_W-1:0];
					REG_BASE_FREQ:   base_reg <= cfg_data[BASE_W-1:0];
					REG_DETUNE:      det_reg  <= cfg_data[DET_W-1:0];
					REG_DUTY:        duty_reg <= cfg_data[DUTY_W-1:0];
					REG_SAMPLE_RATE: rate_reg <= cfg_data[SR_W-1:0];
					default: ;
				endcase
			end
			if (index_valid && !index_stall)
				expected_samples.push_back(predict_sample(sample_index));
			if (sample_valid && !sample_stall) begin
				if (expected_samples.size() == 0) begin
					$error("sample beat with nothing expected: value %0d error %0b",
						sample_value, error);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (sample_value !== want.value) begin
						$error("sample_value: expected %0d, got %0d", want.value, sample_value);
						fail_count++;
					end
					if (error !== want.err) begin
						$error("error: expected %0b, got %0b", want.err, error);
						fail_count++;
					end
				end
			end
			pending <= expected_samples.size();
		end
	end

endmodule

>>> tb/tb_waveform_oscillator_sample.sv
`timescale 1ns / 1ps

module tb_waveform_oscillator_sample;
	import wos_pkg::*;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       index_valid;
	logic                       index_stall;
	logic [IDX_W-1:0]           sample_index;
	logic                       sample_valid;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       error;
	int                         fail_count;
	int                         pending;

	bit burst_mode;
	bit long_hold;

	waveform_oscillator_sample DUT (.*);

	waveform_oscillator_sample_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	// sink side: random stalls, one long hold-off on request
	initial begin
		int r, n;
		sample_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				sample_stall <= 1'b1;
				repeat (300) @(negedge clk);
				long_hold = 1'b0;
			end else if (burst_mode) begin
				sample_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					sample_stall <= 1'b0;
					n = $urandom_range(1, 8);
				end else begin
					sample_stall <= 1'b1;
					n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				end
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_osc(input wave_t w, input bit en, input int amp, input int bf,
			input int det, input int duty, input int rate);
		write_reg(REG_WAVEFORM, CFG_W'(w));
		write_reg(REG_ENABLE, CFG_W'(en));
		write_reg(REG_AMPLITUDE, CFG_W'(amp));
		write_reg(REG_BASE_FREQ, CFG_W'(bf));
		write_reg(REG_DETUNE, CFG_W'(det[DET_W-1:0]));
		write_reg(REG_DUTY, CFG_W'(duty));
		write_reg(REG_SAMPLE_RATE, CFG_W'(rate));
	endtask

	task automatic send_index(input logic [IDX_W-1:0] idx);
		int r, gap;
		index_valid  <= 1'b1;
		sample_index <= idx;
		do @(posedge clk); while (index_stall);
		@(negedge clk);
		r   = $urandom_range(0, 99);
		gap = (burst_mode || r < 60) ? 0 : (r < 92 ? $urandom_range(1, 3)
			: $urandom_range(10, 40));
		if (gap > 0) begin
			index_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain;
		index_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [IDX_W-1:0] rand_index;
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return $urandom;
		return $urandom_range(0, 400000);
	endfunction

	task automatic directed_beats;
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'hFFFFFFFF);
		send_index(32'h80000000);
		send_index(32'hAAAAAAAA);
		send_index(32'h55555555);
		for (int i = 0; i < 6; i++)
			send_index($urandom_range(2, 200));
	endtask

	task automatic random_beats(input int n);
		repeat (n) send_index(rand_index());
	endtask

	initial begin
		int w;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		index_valid  = 1'b0;
		sample_index = '0;
		burst_mode   = 1'b0;
		long_hold    = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset state: disabled, output zero
		directed_beats();
		drain();

		set_osc(WAVE_SINE, 1, 32767, 440, 0, 50, 44100);
		directed_beats();
		random_beats(60);
		drain();
		set_osc(WAVE_SQUARE, 1, 32767, 1000, 0, 1, 48000);
		directed_beats();
		random_beats(40);
		drain();
		set_osc(WAVE_TRIANGLE, 1, 32767, 1000, 0, 100, 48000);
		directed_beats();
		random_beats(40);
		drain();
		set_osc(WAVE_TRIANGLE, 1, 32766, 3000, 5, 1, 44100);
		directed_beats();
		random_beats(40);
		drain();
		// unknown waveform flags an error, but not while disabled
		set_osc(WAVE_UNKNOWN, 1, 100, 440, 0, 50, 44100);
		directed_beats();
		drain();
		set_osc(WAVE_UNKNOWN, 0, 100, 440, 0, 50, 44100);
		directed_beats();
		drain();
		// frequency floor, detune, duty and sample rate limits
		set_osc(WAVE_SINE, 1, 32767, 1, -24, 50, 192000);
		random_beats(30);
		drain();
		set_osc(WAVE_SINE, 1, 32767, 20000, 24, 50, 192000);
		random_beats(30);
		drain();
		set_osc(WAVE_SQUARE, 1, 20000, 32767, 31, 0, 262143);
		random_beats(30);
		drain();
		set_osc(WAVE_TRIANGLE, 1, 20000, 0, -32, 127, 8000);
		random_beats(30);
		drain();
		set_osc(WAVE_TRIANGLE, 1, 0, 440, -1, 99, 0);
		random_beats(20);
		drain();
		set_osc(WAVE_SINE, 1, 12345, 777, 7, 30, 0);
		random_beats(20);
		drain();

		// back-pressure: sink holds off while indices keep coming
		set_osc(WAVE_SINE, 1, 30000, 523, 3, 50, 96000);
		burst_mode = 1'b1;
		long_hold  = 1'b1;
		random_beats(120);
		burst_mode = 1'b0;
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			w = $urandom_range(0, 9);
			set_osc(w < 3 ? WAVE_SINE : (w < 6 ? WAVE_SQUARE : (w < 9 ? WAVE_TRIANGLE
				: WAVE_UNKNOWN)), $urandom_range(0, 9) != 0, $urandom_range(0, 32767),
				$urandom_range(1, 20000), int'($urandom_range(0, 48)) - 24,
				$urandom_range(1, 100), $urandom_range(8000, 192000));
			burst_mode = (ph % 4 == 1);
			random_beats(65);
			burst_mode = 1'b0;
			drain();
		end

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
